@@ design/epsts_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the EEPROM page-split bus-command sequencer.
// No dependencies.
package epsts_pkg;

  localparam int unsigned PAGE_SIZE_DEF = 8;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam logic [19:0] WAIT_TICKS_RST = 20'd500000;
  localparam int unsigned MAX_CMDS = 7;

  typedef enum logic [2:0] {
    CMD_START   = 3'd0,
    CMD_SEND    = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_WAIT    = 3'd3,
    CMD_RX_ACK  = 3'd4,
    CMD_RX_NACK = 3'd5,
    CMD_REJECT  = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    JOB_REJECT = 2'd0,
    JOB_OPEN   = 2'd1,
    JOB_PAGE   = 2'd2,
    JOB_CONT   = 2'd3
  } job_kind_t;

  typedef struct packed {
    logic       operation;
    logic [6:0] device_address;
    logic [7:0] start_address;
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    cmd_t        command;
    logic [7:0]  byte_value;
    logic [19:0] wait_ticks;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    job_kind_t  kind;
    logic       op;
    logic [6:0] dev;
    logic [7:0] addr;
    logic [7:0] data;
    logic       fin;
  } job_t;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] byte_value;
  } seq_ent_t;

endpackage

@@ design/epsts_front.sv @@
`timescale 1ns / 1ps
// Front end: tracks the open transfer and classifies each accepted request into a job.
// Depends on epsts_pkg.
module epsts_front #(
  parameter int unsigned PAGE_SIZE = epsts_pkg::PAGE_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  epsts_pkg::in_item_t item,
  output epsts_pkg::job_t    job
);
  import epsts_pkg::*;

  logic       open_r, open_nxt;
  logic       kind_r, kind_nxt;
  logic [7:0] next_address_r, next_address_nxt;
  logic [6:0] device_r, device_nxt;
  logic       boundary;

  always_comb begin
    boundary = 1'b0;
    for (int k = 0; k < 256; k++) begin
      if ((k % PAGE_SIZE) == 0 && next_address_r == 8'(k)) boundary = 1'b1;
    end
  end

  always_comb begin
    open_nxt         = open_r;
    kind_nxt         = kind_r;
    next_address_nxt = next_address_r;
    device_nxt       = device_r;
    job.op   = item.operation;
    job.data = item.data_byte;
    job.fin  = item.final_byte;
    job.dev  = device_r;
    job.addr = next_address_r;
    priority if (open_r && item.operation != kind_r) begin
      job.kind = JOB_REJECT;
    end else if (!open_r) begin
      job.kind         = JOB_OPEN;
      job.dev          = item.device_address;
      job.addr         = item.start_address;
      kind_nxt         = item.operation;
      device_nxt       = item.device_address;
      next_address_nxt = item.start_address + 8'd1;
      open_nxt         = !item.final_byte;
    end else begin
      job.kind         = (!item.operation && boundary) ? JOB_PAGE : JOB_CONT;
      next_address_nxt = next_address_r + 8'd1;
      open_nxt         = !item.final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r         <= 1'b0;
      kind_r         <= 1'b0;
      next_address_r <= 8'd0;
      device_r       <= 7'd0;
    end else if (accept) begin
      open_r         <= open_nxt;
      kind_r         <= kind_nxt;
      next_address_r <= next_address_nxt;
      device_r       <= device_nxt;
    end
  end

endmodule

@@ design/epsts_queue.sv @@
`timescale 1ns / 1ps
// Small job queue between front end and command sequencer.
// Depends on epsts_pkg.
module epsts_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  epsts_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output epsts_pkg::job_t head_job
);
  import epsts_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  job_t            mem_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;

  assign full       = (count_r == CW'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PW'(1);
      unique case ({push, pop})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) !head_valid |-> !pop)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("queue count overflow");

endmodule

@@ design/epsts_back.sv @@
`timescale 1ns / 1ps
// Back end: expands jobs into bus commands in the output register, one per cycle unless stalled.
// Depends on epsts_pkg.
module epsts_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  epsts_pkg::job_t      head_job,
  output logic                 pop,
  input  logic [19:0]          wait_ticks,
  output logic                 out_valid,
  input  logic                 out_stall,
  output epsts_pkg::out_item_t out_item
);
  import epsts_pkg::*;

  seq_ent_t   seq [MAX_CMDS];
  logic [2:0] seq_len;
  logic [2:0] step_r;
  logic       out_valid_r;
  out_item_t  out_item_r;
  logic       emit, last_step;
  seq_ent_t   cur;

  always_comb begin
    logic [2:0] n;
    logic [7:0] dev_w;
    n = '0;
    dev_w = {head_job.dev, 1'b0};
    for (int i = 0; i < MAX_CMDS; i++) seq[i] = '{CMD_START, 8'h00};
    unique case (head_job.kind)
      JOB_REJECT: begin
        seq[n] = '{CMD_REJECT, 8'h00}; n = n + 3'd1;
      end
      JOB_OPEN: begin
        seq[n] = '{CMD_START, 8'h00};       n = n + 3'd1;
        seq[n] = '{CMD_SEND, dev_w};        n = n + 3'd1;
        seq[n] = '{CMD_SEND, head_job.addr}; n = n + 3'd1;
        if (head_job.op) begin
          seq[n] = '{CMD_START, 8'h00};             n = n + 3'd1;
          seq[n] = '{CMD_SEND, dev_w | 8'h01};      n = n + 3'd1;
        end
      end
      JOB_PAGE: begin
        seq[n] = '{CMD_STOP, 8'h00};        n = n + 3'd1;
        seq[n] = '{CMD_WAIT, 8'h00};        n = n + 3'd1;
        seq[n] = '{CMD_START, 8'h00};       n = n + 3'd1;
        seq[n] = '{CMD_SEND, dev_w};        n = n + 3'd1;
        seq[n] = '{CMD_SEND, head_job.addr}; n = n + 3'd1;
      end
      default: ;
    endcase
    if (head_job.kind != JOB_REJECT) begin
      if (!head_job.op)      seq[n] = '{CMD_SEND, head_job.data};
      else if (head_job.fin) seq[n] = '{CMD_RX_NACK, 8'h00};
      else                   seq[n] = '{CMD_RX_ACK, 8'h00};
      n = n + 3'd1;
      if (head_job.fin) begin
        seq[n] = '{CMD_STOP, 8'h00}; n = n + 3'd1;
      end
    end
    seq_len = n;
  end

  assign emit      = head_valid && (!out_valid_r || !out_stall);
  assign last_step = (step_r == seq_len - 3'd1);
  assign pop       = emit && last_step;
  assign cur       = seq[step_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
        step_r      <= last_step ? 3'd0 : step_r + 3'd1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item_r.command     <= cur.command;
      out_item_r.byte_value  <= cur.byte_value;
      out_item_r.wait_ticks  <= (cur.command == CMD_WAIT) ? wait_ticks : 20'd0;
      out_item_r.last_of_run <= last_step;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> step_r < seq_len)
    else $error("sequencer step beyond job length");
  a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.command == CMD_REJECT |-> out_item_r.last_of_run)
    else $error("reject not last of run");
  a_step_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> step_r == 3'd0)
    else $error("step not cleared after job");
  a_wait_nonzero_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.command != CMD_WAIT |-> out_item_r.wait_ticks == 20'd0)
    else $error("wait ticks on non-wait command");

endmodule

@@ design/eeprom_page_split_transaction_sequencer_core.sv @@
`timescale 1ns / 1ps
// Top level of the EEPROM page-split bus-command sequencer.
// Depends on epsts_pkg, epsts_front, epsts_queue, epsts_back.
//
// Usage:
//   in_*  : one byte request per beat (write byte or read slot), valid/stall.
//   out_* : bus commands, one per beat, valid/stall; last_of_run marks the
//           final command of a request.
//   cfg_* : write-wait tick count, valid/ready, always ready; write it only
//           while no request is in flight.
// An accepted request is written into the job queue, and its first command
// is then registered into the output register before it is presented.
// Throughput: a request expands into 1 to 7 commands and the back-end
// sequencer emits one command per cycle while the output is not stalled.
// The front end and a four-entry job queue keep accepting requests while
// commands drain.
// Reset: no transfer open, wait ticks 500000, queue and output empty.
// A stalled receiver holds the output beat; the queue then fills and
// in_stall rises once it is full.
module eeprom_page_split_transaction_sequencer_core #(
  parameter int unsigned PAGE_SIZE = epsts_pkg::PAGE_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  epsts_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output epsts_pkg::out_item_t out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [19:0]          cfg_wdata
);
  import epsts_pkg::*;

  logic [19:0] wait_ticks_r;
  logic        accept, full, pop, head_valid;
  job_t        job, head_job;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_ticks_r <= WAIT_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      wait_ticks_r <= cfg_wdata;
    end
  end

  epsts_front #(.PAGE_SIZE(PAGE_SIZE)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_item),
    .job    (job)
  );

  epsts_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_job   (job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  epsts_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .wait_ticks (wait_ticks_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule
